@@ src/lod_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_pkg: shared types and constants of the lift-off detector
// Configuration layout, reset values, phase encoding and the counter defaults.
// ----------------------------------------------------------------------------
package lod_pkg;

	localparam int COUNT_WIDTH_DEF = 12;
	localparam int CFG_CNT_W       = 12;
	localparam int CFG_IDX_W       = 3;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] IDX_STILL_LIMIT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_STILL_TICKS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_LIFT_TIMEOUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_ACCEL_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_ANGLE_LOW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] IDX_ANGLE_HIGH      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_SPIN_TIMEOUT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPIN_THRESHOLD  = 3'd7;

	localparam logic [15:0]          RST_STILL_LIMIT     = 16'd15;
	localparam logic [CFG_CNT_W-1:0] RST_STILL_TICKS     = 12'd10;
	localparam logic [CFG_CNT_W-1:0] RST_LIFT_TIMEOUT    = 12'd400;
	localparam logic signed [15:0]   RST_ACCEL_THRESHOLD = 16'sd27000;
	localparam logic signed [12:0]   RST_ANGLE_LOW       = -13'sd192;
	localparam logic signed [12:0]   RST_ANGLE_HIGH      = 13'sd256;
	localparam logic [CFG_CNT_W-1:0] RST_SPIN_TIMEOUT    = 12'd200;
	localparam logic [15:0]          RST_SPIN_THRESHOLD  = 16'd300;

	typedef struct packed {
		logic [15:0]          still_limit;
		logic [CFG_CNT_W-1:0] still_ticks;
		logic [CFG_CNT_W-1:0] lift_timeout;
		logic signed [15:0]   accel_threshold;
		logic signed [12:0]   angle_low;
		logic signed [12:0]   angle_high;
		logic [CFG_CNT_W-1:0] spin_timeout;
		logic [15:0]          spin_threshold;
	} lod_cfg_t;

	typedef enum logic [2:0] {
		PH_STILL = 3'b001,
		PH_LIFT  = 3'b010,
		PH_SPIN  = 3'b100
	} lod_phase_t;

	// phase as reported on the result word
	localparam logic [1:0] PHASE_CODE_STILL = 2'd0;
	localparam logic [1:0] PHASE_CODE_LIFT  = 2'd1;
	localparam logic [1:0] PHASE_CODE_SPIN  = 2'd2;

endpackage

@@ src/lod_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_cfg_regs: configuration register file
// Eight thresholds and timeouts, written by index over a valid/ready channel.
// ----------------------------------------------------------------------------
module lod_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lod_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                  cfg_data,
	output lod_pkg::lod_cfg_t            cfg
);

	lod_pkg::lod_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.still_limit     <= lod_pkg::RST_STILL_LIMIT;
			cfg_q.still_ticks     <= lod_pkg::RST_STILL_TICKS;
			cfg_q.lift_timeout    <= lod_pkg::RST_LIFT_TIMEOUT;
			cfg_q.accel_threshold <= lod_pkg::RST_ACCEL_THRESHOLD;
			cfg_q.angle_low       <= lod_pkg::RST_ANGLE_LOW;
			cfg_q.angle_high      <= lod_pkg::RST_ANGLE_HIGH;
			cfg_q.spin_timeout    <= lod_pkg::RST_SPIN_TIMEOUT;
			cfg_q.spin_threshold  <= lod_pkg::RST_SPIN_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lod_pkg::IDX_STILL_LIMIT: begin
					cfg_q.still_limit <= cfg_data;
				end
				lod_pkg::IDX_STILL_TICKS: begin
					cfg_q.still_ticks <= cfg_data[lod_pkg::CFG_CNT_W-1:0];
				end
				lod_pkg::IDX_LIFT_TIMEOUT: begin
					cfg_q.lift_timeout <= cfg_data[lod_pkg::CFG_CNT_W-1:0];
				end
				lod_pkg::IDX_ACCEL_THRESHOLD: begin
					cfg_q.accel_threshold <= cfg_data;
				end
				lod_pkg::IDX_ANGLE_LOW: begin
					cfg_q.angle_low <= cfg_data[12:0];
				end
				lod_pkg::IDX_ANGLE_HIGH: begin
					cfg_q.angle_high <= cfg_data[12:0];
				end
				lod_pkg::IDX_SPIN_TIMEOUT: begin
					cfg_q.spin_timeout <= cfg_data[lod_pkg::CFG_CNT_W-1:0];
				end
				lod_pkg::IDX_SPIN_THRESHOLD: begin
					cfg_q.spin_threshold <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

@@ src/lod_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_step: one tick of the phase sequencer
// Runs still watch, lift wait and spin wait in order on one word and gives
// the next phase, next counters and the pick-up flag.
// ----------------------------------------------------------------------------
module lod_step #(
	parameter int COUNT_WIDTH = lod_pkg::COUNT_WIDTH_DEF
) (
	input  lod_pkg::lod_cfg_t        cfg,
	input  lod_pkg::lod_phase_t      phase_cur,
	input  logic [COUNT_WIDTH-1:0]   still_run_cur,
	input  logic [COUNT_WIDTH-1:0]   lift_wait_cur,
	input  logic [COUNT_WIDTH-1:0]   spin_wait_cur,
	input  logic signed [15:0]       z_accel,
	input  logic signed [12:0]       tilt_angle,
	input  logic signed [15:0]       left_count,
	input  logic signed [15:0]       right_count,
	output lod_pkg::lod_phase_t      phase_nxt,
	output logic [COUNT_WIDTH-1:0]   still_run_nxt,
	output logic [COUNT_WIDTH-1:0]   lift_wait_nxt,
	output logic [COUNT_WIDTH-1:0]   spin_wait_nxt,
	output logic                     pick
);

	localparam int CMP_W = (COUNT_WIDTH > lod_pkg::CFG_CNT_W) ? COUNT_WIDTH
	                                                          : lod_pkg::CFG_CNT_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_TOP = {COUNT_WIDTH{1'b1}};

	logic signed [17:0] left_x, right_x, sum_x;
	logic [17:0]        left_mag, right_mag, mag_sum, sum_mag;
	logic               still, lift, runaway;

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		return (c == CNT_TOP) ? c : c + 1'b1;
	endfunction

	// counter strictly above a 12-bit register, compared at common width
	function automatic logic over(input logic [COUNT_WIDTH-1:0] c,
	                              input logic [lod_pkg::CFG_CNT_W-1:0] lim);
		logic [CMP_W-1:0] c_x, lim_x;
		c_x   = CMP_W'(c);
		lim_x = CMP_W'(lim);
		return c_x > lim_x;
	endfunction

	always_comb begin
		left_x    = 18'(left_count);
		right_x   = 18'(right_count);
		sum_x     = left_x + right_x;
		left_mag  = left_x[17] ? 18'(-left_x) : 18'(left_x);
		right_mag = right_x[17] ? 18'(-right_x) : 18'(right_x);
		sum_mag   = sum_x[17] ? 18'(-sum_x) : 18'(sum_x);
		mag_sum   = left_mag + right_mag;
		still     = mag_sum < {2'b00, cfg.still_limit};
		runaway   = sum_mag > {2'b00, cfg.spin_threshold};
		lift      = (z_accel > cfg.accel_threshold) &&
		            (tilt_angle > cfg.angle_low) && (tilt_angle < cfg.angle_high);
	end

	// phases fall through in order within one tick
	always_comb begin
		phase_nxt     = phase_cur;
		still_run_nxt = still_run_cur;
		lift_wait_nxt = lift_wait_cur;
		spin_wait_nxt = spin_wait_cur;
		pick          = 1'b0;

		if (phase_cur != lod_pkg::PH_STILL && phase_cur != lod_pkg::PH_LIFT &&
		    phase_cur != lod_pkg::PH_SPIN) begin
			phase_nxt = lod_pkg::PH_STILL;
		end

		if (phase_nxt == lod_pkg::PH_STILL) begin
			still_run_nxt = still ? bump(still_run_nxt) : '0;
			if (over(still_run_nxt, cfg.still_ticks)) begin
				phase_nxt     = lod_pkg::PH_LIFT;
				still_run_nxt = '0;
			end
		end

		if (phase_nxt == lod_pkg::PH_LIFT) begin
			lift_wait_nxt = bump(lift_wait_nxt);
			if (over(lift_wait_nxt, cfg.lift_timeout)) begin
				lift_wait_nxt = '0;
				phase_nxt     = lod_pkg::PH_STILL;
			end
			// lift seen still wins over a timeout on the same tick
			if (lift) begin
				phase_nxt = lod_pkg::PH_SPIN;
			end
		end

		if (phase_nxt == lod_pkg::PH_SPIN) begin
			spin_wait_nxt = bump(spin_wait_nxt);
			if (over(spin_wait_nxt, cfg.spin_timeout)) begin
				spin_wait_nxt = '0;
				phase_nxt     = lod_pkg::PH_STILL;
			end
			if (runaway) begin
				phase_nxt = lod_pkg::PH_STILL;
				pick      = 1'b1;
			end
		end
	end

endmodule

@@ src/lift_off_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_off_detector_core: pick-up detector for a balancing robot
// Watches for stillness, then an upward jolt near level tilt, then wheel
// runaway, and flags a pick-up.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall is low and returns exactly one result
// word per input word: the word lands in an input register, the phase sequencer
// runs through all three phases in one combinational pass, and the result lands
// in an output register. The phase and counter registers update on the same edge
// as the result register, so the next word sees them at once. When the output is
// stalled, one more word is held in the input register before in_stall rises.
// Configuration writes are always ready and take effect at once; write them only
// while idle.
module lift_off_detector_core #(
	parameter int COUNT_WIDTH = lod_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lod_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            z_accel,
	input  logic signed [12:0]            tilt_angle,
	input  logic signed [15:0]            left_count,
	input  logic signed [15:0]            right_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          picked_up,
	output logic [1:0]                    phase
);

	lod_pkg::lod_cfg_t   cfg;
	lod_pkg::lod_phase_t phase_q, phase_nxt;
	logic [COUNT_WIDTH-1:0] still_run_q, lift_wait_q, spin_wait_q;
	logic [COUNT_WIDTH-1:0] still_run_nxt, lift_wait_nxt, spin_wait_nxt;
	logic                   pick;

	logic                s1_valid_q;
	logic signed [15:0]  z_accel_s1, left_count_s1, right_count_s1;
	logic signed [12:0]  tilt_angle_s1;
	logic                out_valid_q, picked_up_q;
	logic [1:0]          phase_out_q;
	logic                advance, in_take, step;

	lod_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lod_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
		.cfg           (cfg),
		.phase_cur     (phase_q),
		.still_run_cur (still_run_q),
		.lift_wait_cur (lift_wait_q),
		.spin_wait_cur (spin_wait_q),
		.z_accel       (z_accel_s1),
		.tilt_angle    (tilt_angle_s1),
		.left_count    (left_count_s1),
		.right_count   (right_count_s1),
		.phase_nxt     (phase_nxt),
		.still_run_nxt (still_run_nxt),
		.lift_wait_nxt (lift_wait_nxt),
		.spin_wait_nxt (spin_wait_nxt),
		.pick          (pick)
	);

	// output register can take a word when empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !advance;
	assign in_take  = in_valid && !in_stall;
	assign step     = s1_valid_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			z_accel_s1     <= z_accel;
			tilt_angle_s1  <= tilt_angle;
			left_count_s1  <= left_count;
			right_count_s1 <= right_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lod_pkg::PH_STILL;
			still_run_q <= '0;
			lift_wait_q <= '0;
			spin_wait_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_nxt;
				still_run_q <= still_run_nxt;
				lift_wait_q <= lift_wait_nxt;
				spin_wait_q <= spin_wait_nxt;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			picked_up_q <= pick;
			case (phase_nxt)
				lod_pkg::PH_LIFT: begin
					phase_out_q <= lod_pkg::PHASE_CODE_LIFT;
				end
				lod_pkg::PH_SPIN: begin
					phase_out_q <= lod_pkg::PHASE_CODE_SPIN;
				end
				default: begin
					phase_out_q <= lod_pkg::PHASE_CODE_STILL;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign picked_up = picked_up_q;
	assign phase     = phase_out_q;

	// a pick-up always returns the sequencer to still watch
	a_pick_to_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && picked_up |-> phase == lod_pkg::PHASE_CODE_STILL)
		else $error("pick-up reported outside still watch");

	// the still counter is cleared whenever still watch is left
	a_still_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		still_run_q != '0 |-> phase_q == lod_pkg::PH_STILL)
		else $error("still counter live outside still watch");

	// a word processed from the input register shows up as a result
	a_step_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("processed word lost before output");

	// the reported phase never takes the unused code
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (phase == lod_pkg::PHASE_CODE_STILL ||
		               phase == lod_pkg::PHASE_CODE_LIFT ||
		               phase == lod_pkg::PHASE_CODE_SPIN))
		else $error("unused phase code on output");

endmodule
